// File: src/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off during reset
`define CHK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked on every rising clock edge, off during reset
`define CHK_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked on every rising clock edge, off during reset
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/pbp_pkg.sv
// shared types and constants of the page buffer pool
`timescale 1ns / 1ps
`default_nettype none

package pbp_pkg;

   localparam int NUM_FRAMES_DEF = 16;
   localparam int PIN_BITS_DEF   = 8;
   localparam int MAX_RESULTS    = 16;
   localparam int WALK_W         = $clog2(MAX_RESULTS);
   localparam int ID_W           = 31;
   localparam int FRAME_W        = 6;
   localparam int POS_W          = 6;
   localparam int CMD_W          = 3;
   localparam int FILL_W         = 2;

   localparam logic [CMD_W-1:0] CMD_FETCH     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_UNPIN     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_NEW       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FLUSH_ALL = 3'd5;

   localparam logic [FILL_W-1:0] FILL_NONE = 2'd0;
   localparam logic [FILL_W-1:0] FILL_READ = 2'd1;
   localparam logic [FILL_W-1:0] FILL_ZERO = 2'd2;

   // broadcast to every cell; the selected cell takes the per-frame operation
   typedef struct packed {
      logic             install;
      logic             pin_up;
      logic             unpin;
      logic             clr_dirty;
      logic             kill;
      logic             free_pop;
      logic             lru_pop;
      logic             lru_rm;
      logic [POS_W-1:0] rm_pos;
      logic [POS_W-1:0] tail_pos;
      logic [ID_W-1:0]  page;
      logic             md;
   } cell_ctl_type;

   // what each cell reports back
   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic             hit_first;
      logic             dirty_first;
      logic             pin_zero;
      logic             pin_one;
      logic             pin_max;
      logic             free_head;
      logic             lru_head;
      logic [POS_W-1:0] pos;
      logic [ID_W-1:0]  page;
   } cell_stat_type;

endpackage

`default_nettype wire

// File: src/page_buffer_pool_lru.sv
// top level of the page buffer pool with least-recently-unpinned replacement
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/ready   | command, page_id, mark_dirty, new_page_id
//  rsp     | out       | rsp_valid/ready   | status, frame, write_back, write_page_id,
//          |           |                   | fill_kind, release_page, last
//
// a command passes accept, associative lookup over the row of frame cells, then the
// update of the cells (the walk for flush all), which waits for a free output register
// and loads the result beat into it; the next command can be taken once back in idle
// flush all offers one beat per cycle per dirty frame (up to 16) while the output
// register is free, found by the dirty carry that ripples down the cell row
// a new command is accepted while the last result beat still waits in the
// output register; a stalled output register stalls the update step
// synchronous reset empties the pool: all frames free, in index order
`timescale 1ns / 1ps
`default_nettype none

module page_buffer_pool_lru #(
   parameter int NUM_FRAMES = pbp_pkg::NUM_FRAMES_DEF,
   parameter int PIN_BITS   = pbp_pkg::PIN_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [pbp_pkg::CMD_W-1:0]   req_command,
   input  wire logic [pbp_pkg::ID_W-1:0]    req_page_id,
   input  wire logic                        req_mark_dirty,
   input  wire logic [pbp_pkg::ID_W-1:0]    req_new_page_id,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic                        rsp_status,
   output      logic [pbp_pkg::FRAME_W-1:0] rsp_frame,
   output      logic                        rsp_write_back,
   output      logic [pbp_pkg::ID_W-1:0]    rsp_write_page_id,
   output      logic [pbp_pkg::FILL_W-1:0]  rsp_fill_kind,
   output      logic                        rsp_release_page,
   output      logic                        rsp_last
);

   localparam int CNT_W = $clog2(NUM_FRAMES + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MATCH = 4'b0010,
      S_EXEC  = 4'b0100,
      S_WALK  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // captured command
   logic [pbp_pkg::CMD_W-1:0] cmd_ff;
   logic [pbp_pkg::ID_W-1:0]  pid_ff, key_ff;
   logic                      md_ff;

   // queue fill counts
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0] lru_cnt_ff, lru_cnt_in;
   logic [pbp_pkg::WALK_W-1:0] walk_ff, walk_in;

   // lookup results, held for the update step
   logic [NUM_FRAMES-1:0]       hit_oh_ff, hit_oh_c;
   logic                        hit_ok_ff;
   logic                        hit_pz_ff, hit_p1_ff, hit_pm_ff;
   logic [pbp_pkg::POS_W-1:0]   hit_pos_ff, hit_pos_c;
   logic [pbp_pkg::FRAME_W-1:0] hit_idx_ff, hit_idx_c;
   logic                        hit_pz_c, hit_p1_c, hit_pm_c;
   logic [NUM_FRAMES-1:0]       vic_oh_ff, vic_oh_c;
   logic                        vic_ok_ff, vic_free_ff, vic_wb_ff, vic_wb_c;
   logic [pbp_pkg::ID_W-1:0]    vic_page_ff, vic_page_c;
   logic [pbp_pkg::FRAME_W-1:0] vic_idx_ff, vic_idx_c;

   // cell row
   pbp_pkg::cell_ctl_type  ctl;
   logic [NUM_FRAMES-1:0]  sel;
   pbp_pkg::cell_stat_type stat [NUM_FRAMES];
   logic [NUM_FRAMES:0]    hit_chain, dirty_chain;

   // walk selection
   logic [NUM_FRAMES-1:0]       dsel, dmask;
   logic                        d_others;
   logic [pbp_pkg::ID_W-1:0]    d_page;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        r_status, r_wb, r_rel, r_last, load, slot_free, inst;
   logic [pbp_pkg::FRAME_W-1:0] r_frame;
   logic [pbp_pkg::ID_W-1:0]    r_wpid;
   logic [pbp_pkg::FILL_W-1:0]  r_fill, inst_fill;
   logic                        o_status_ff, o_wb_ff, o_rel_ff, o_last_ff;
   logic [pbp_pkg::FRAME_W-1:0] o_frame_ff;
   logic [pbp_pkg::ID_W-1:0]    o_wpid_ff;
   logic [pbp_pkg::FILL_W-1:0]  o_fill_ff;

   assign hit_chain[0]   = 1'b0;
   assign dirty_chain[0] = 1'b0;

   for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
      pbp_cell #(
         .PIN_BITS  (PIN_BITS),
         .RESET_POS (g)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .key            (key_ff),
         .ctl            (ctl),
         .sel            (sel[g]),
         .hit_seen_in    (hit_chain[g]),
         .hit_seen_out   (hit_chain[g+1]),
         .dirty_seen_in  (dirty_chain[g]),
         .dirty_seen_out (dirty_chain[g+1]),
         .stat           (stat[g])
      );
   end

   // gather per-frame reports into the lookup result
   always_comb begin
      hit_pos_c  = '0;
      hit_idx_c  = '0;
      hit_pz_c   = 1'b0;
      hit_p1_c   = 1'b0;
      hit_pm_c   = 1'b0;
      vic_wb_c   = 1'b0;
      vic_page_c = '0;
      vic_idx_c  = '0;
      d_page     = '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         hit_oh_c[i] = stat[i].hit_first;
         vic_oh_c[i] = (free_cnt_ff != '0) ? stat[i].free_head : stat[i].lru_head;
         dsel[i]     = stat[i].dirty_first;
         dmask[i]    = stat[i].valid & stat[i].dirty;
         if (stat[i].hit_first) begin
            hit_pos_c = hit_pos_c | stat[i].pos;
            hit_idx_c = hit_idx_c | pbp_pkg::FRAME_W'(i);
            hit_pz_c  = hit_pz_c | stat[i].pin_zero;
            hit_p1_c  = hit_p1_c | stat[i].pin_one;
            hit_pm_c  = hit_pm_c | stat[i].pin_max;
         end
         if (vic_oh_c[i]) begin
            vic_wb_c   = vic_wb_c | (stat[i].valid & stat[i].dirty);
            vic_page_c = vic_page_c | stat[i].page;
            vic_idx_c  = vic_idx_c | pbp_pkg::FRAME_W'(i);
         end
         if (stat[i].dirty_first) d_page = d_page | stat[i].page;
      end
      d_others = |(dmask & ~dsel);
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   // no beat is taken while reset is held
   assign req_ready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      state_in     = state_ff;
      free_cnt_in  = free_cnt_ff;
      lru_cnt_in   = lru_cnt_ff;
      walk_in      = walk_ff;
      ctl          = '0;
      ctl.page     = key_ff;
      ctl.md       = md_ff;
      ctl.rm_pos   = hit_pos_ff;
      sel          = '0;
      load         = 1'b0;
      inst         = 1'b0;
      inst_fill    = pbp_pkg::FILL_NONE;
      r_status     = 1'b0;
      r_frame      = '0;
      r_wb         = 1'b0;
      r_wpid       = '0;
      r_fill       = pbp_pkg::FILL_NONE;
      r_rel        = 1'b0;
      r_last       = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_MATCH;
         end
         S_MATCH: begin
            walk_in  = '0;
            state_in = (cmd_ff == pbp_pkg::CMD_FLUSH_ALL) ? S_WALK : S_EXEC;
         end
         S_EXEC: begin
            if (slot_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
               case (cmd_ff)
                  pbp_pkg::CMD_FETCH: begin
                     if (hit_ok_ff) begin
                        if (hit_pm_ff) begin
                           r_status = 1'b1;
                        end else begin
                           ctl.pin_up = 1'b1;
                           sel        = hit_oh_ff;
                           r_frame    = hit_idx_ff;
                           // a hit on an unpinned frame pulls it out of the lru order
                           if (hit_pz_ff) begin
                              ctl.lru_rm = 1'b1;
                              lru_cnt_in = lru_cnt_ff - 1'b1;
                           end
                        end
                     end else begin
                        inst      = 1'b1;
                        inst_fill = pbp_pkg::FILL_READ;
                     end
                  end
                  pbp_pkg::CMD_UNPIN: begin
                     if (!hit_ok_ff || hit_pz_ff) begin
                        r_status = 1'b1;
                     end else begin
                        ctl.unpin    = 1'b1;
                        ctl.tail_pos = pbp_pkg::POS_W'(lru_cnt_ff);
                        sel          = hit_oh_ff;
                        if (hit_p1_ff) lru_cnt_in = lru_cnt_ff + 1'b1;
                     end
                  end
                  pbp_pkg::CMD_FLUSH: begin
                     if (!hit_ok_ff) begin
                        r_status = 1'b1;
                     end else begin
                        ctl.clr_dirty = 1'b1;
                        sel           = hit_oh_ff;
                        r_wb          = 1'b1;
                        r_wpid        = pid_ff;
                     end
                  end
                  pbp_pkg::CMD_NEW: begin
                     if (hit_ok_ff) begin
                        r_status = 1'b1;
                     end else begin
                        inst      = 1'b1;
                        inst_fill = pbp_pkg::FILL_ZERO;
                     end
                  end
                  pbp_pkg::CMD_DELETE: begin
                     if (hit_ok_ff) begin
                        if (!hit_pz_ff) begin
                           r_status = 1'b1;
                        end else begin
                           // unpinned frame: leave lru order, join free tail
                           ctl.kill     = 1'b1;
                           ctl.lru_rm   = 1'b1;
                           ctl.tail_pos = pbp_pkg::POS_W'(free_cnt_ff);
                           sel          = hit_oh_ff;
                           lru_cnt_in   = lru_cnt_ff - 1'b1;
                           free_cnt_in  = free_cnt_ff + 1'b1;
                           r_rel        = 1'b1;
                        end
                     end
                  end
                  default: begin
                     r_status = 1'b1;
                  end
               endcase
               // victim refill shared by fetch miss and new page
               if (inst) begin
                  if (!vic_ok_ff) begin
                     r_status = 1'b1;
                  end else begin
                     ctl.install = 1'b1;
                     sel         = vic_oh_ff;
                     r_frame     = vic_idx_ff;
                     r_wb        = vic_wb_ff;
                     r_wpid      = vic_wb_ff ? vic_page_ff : '0;
                     r_fill      = inst_fill;
                     if (vic_free_ff) begin
                        ctl.free_pop = 1'b1;
                        free_cnt_in  = free_cnt_ff - 1'b1;
                     end else begin
                        ctl.lru_pop = 1'b1;
                        lru_cnt_in  = lru_cnt_ff - 1'b1;
                     end
                  end
               end
            end
         end
         S_WALK: begin
            if (slot_free) begin
               load = 1'b1;
               if (!dirty_chain[NUM_FRAMES]) begin
                  state_in = S_IDLE;
               end else begin
                  ctl.clr_dirty = 1'b1;
                  sel           = dsel;
                  r_wb          = 1'b1;
                  r_wpid        = d_page;
                  r_last        = !d_others ||
                                  (walk_ff == pbp_pkg::WALK_W'(pbp_pkg::MAX_RESULTS - 1));
                  walk_in       = walk_ff + 1'b1;
                  if (r_last) state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_cnt_ff  <= CNT_W'(NUM_FRAMES);
         lru_cnt_ff   <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_cnt_ff  <= free_cnt_in;
         lru_cnt_ff   <= lru_cnt_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_command;
         pid_ff <= req_page_id;
         md_ff  <= req_mark_dirty;
         key_ff <= (req_command == pbp_pkg::CMD_NEW) ? req_new_page_id : req_page_id;
      end
      if (state_ff == S_MATCH) begin
         hit_oh_ff   <= hit_oh_c;
         hit_ok_ff   <= hit_chain[NUM_FRAMES];
         hit_pz_ff   <= hit_pz_c;
         hit_p1_ff   <= hit_p1_c;
         hit_pm_ff   <= hit_pm_c;
         hit_pos_ff  <= hit_pos_c;
         hit_idx_ff  <= hit_idx_c;
         vic_oh_ff   <= vic_oh_c;
         vic_ok_ff   <= (free_cnt_ff != '0) || (lru_cnt_ff != '0);
         vic_free_ff <= (free_cnt_ff != '0);
         vic_wb_ff   <= vic_wb_c;
         vic_page_ff <= vic_page_c;
         vic_idx_ff  <= vic_idx_c;
      end
      if (load) begin
         o_status_ff <= r_status;
         o_frame_ff  <= r_frame;
         o_wb_ff     <= r_wb;
         o_wpid_ff   <= r_wpid;
         o_fill_ff   <= r_fill;
         o_rel_ff    <= r_rel;
         o_last_ff   <= r_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_frame         = o_frame_ff;
   assign rsp_write_back    = o_wb_ff;
   assign rsp_write_page_id = o_wpid_ff;
   assign rsp_fill_kind     = o_fill_ff;
   assign rsp_release_page  = o_rel_ff;
   assign rsp_last          = o_last_ff;

endmodule

`default_nettype wire

// File: src/pbp_cell.sv
// one frame of the pool: page id, pin count, dirty mark and queue position
`timescale 1ns / 1ps
`default_nettype none

module pbp_cell #(
   parameter int PIN_BITS  = pbp_pkg::PIN_BITS_DEF,
   parameter int RESET_POS = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [pbp_pkg::ID_W-1:0] key,
   input  wire pbp_pkg::cell_ctl_type  ctl,
   input  wire logic                   sel,
   input  wire logic                   hit_seen_in,
   output      logic                   hit_seen_out,
   input  wire logic                   dirty_seen_in,
   output      logic                   dirty_seen_out,
   output      pbp_pkg::cell_stat_type stat
);

   logic [pbp_pkg::ID_W-1:0]  page_ff, page_in;
   logic                      valid_ff, valid_in;
   logic [PIN_BITS-1:0]       pin_ff, pin_in;
   logic                      dirty_ff, dirty_in;
   logic [pbp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                      in_lru, match, dmark;

   assign in_lru = valid_ff && (pin_ff == '0);
   assign match  = valid_ff && (page_ff == key);
   assign dmark  = valid_ff && dirty_ff;

   // first-match carries ripple down the row
   assign hit_seen_out   = hit_seen_in | match;
   assign dirty_seen_out = dirty_seen_in | dmark;

   always_comb begin
      stat             = '0;
      stat.valid       = valid_ff;
      stat.dirty       = dirty_ff;
      stat.hit_first   = match & ~hit_seen_in;
      stat.dirty_first = dmark & ~dirty_seen_in;
      stat.pin_zero    = (pin_ff == '0);
      stat.pin_one     = (pin_ff == PIN_BITS'(1));
      stat.pin_max     = &pin_ff;
      stat.free_head   = !valid_ff && (pos_ff == '0);
      stat.lru_head    = in_lru && (pos_ff == '0);
      stat.pos         = pos_ff;
      stat.page        = page_ff;
   end

   always_comb begin
      page_in  = page_ff;
      valid_in = valid_ff;
      pin_in   = pin_ff;
      dirty_in = dirty_ff;
      pos_in   = pos_ff;
      // queue shifts for cells behind a removed entry
      if (ctl.free_pop && !valid_ff && (pos_ff != '0)) pos_in = pos_ff - 1'b1;
      if (ctl.lru_pop && in_lru && (pos_ff != '0)) pos_in = pos_ff - 1'b1;
      if (ctl.lru_rm && in_lru && (pos_ff > ctl.rm_pos)) pos_in = pos_ff - 1'b1;
      if (sel) begin
         if (ctl.install) begin
            page_in  = ctl.page;
            valid_in = 1'b1;
            pin_in   = PIN_BITS'(1);
            dirty_in = 1'b0;
         end
         if (ctl.pin_up) pin_in = pin_ff + 1'b1;
         if (ctl.unpin) begin
            dirty_in = dirty_ff | ctl.md;
            pin_in   = pin_ff - 1'b1;
            if (pin_ff == PIN_BITS'(1)) pos_in = ctl.tail_pos;
         end
         if (ctl.clr_dirty) dirty_in = 1'b0;
         if (ctl.kill) begin
            valid_in = 1'b0;
            dirty_in = 1'b0;
            pin_in   = '0;
            pos_in   = ctl.tail_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      if (reset) begin
         valid_ff <= 1'b0;
         pin_ff   <= '0;
         dirty_ff <= 1'b0;
         pos_ff   <= pbp_pkg::POS_W'(RESET_POS);
      end else begin
         valid_ff <= valid_in;
         pin_ff   <= pin_in;
         dirty_ff <= dirty_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

`default_nettype wire

// File: src/pbp_checker.sv
// port-level checker of the page buffer pool, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pbp_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        rsp_status,
   input wire logic [pbp_pkg::FRAME_W-1:0] rsp_frame,
   input wire logic                        rsp_write_back,
   input wire logic [pbp_pkg::ID_W-1:0]    rsp_write_page_id,
   input wire logic [pbp_pkg::FILL_W-1:0]  rsp_fill_kind,
   input wire logic                        rsp_release_page,
   input wire logic                        rsp_last
);

   logic side_fx, fill_known;

   // anything a failed beat must not carry
   assign side_fx    = rsp_write_back || (rsp_frame != '0) ||
                       (rsp_fill_kind != pbp_pkg::FILL_NONE) || rsp_release_page;
   assign fill_known = (rsp_fill_kind == pbp_pkg::FILL_NONE) ||
                       (rsp_fill_kind == pbp_pkg::FILL_READ) ||
                       (rsp_fill_kind == pbp_pkg::FILL_ZERO);

   `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_write_page_id), "rsp beat dropped")
   `CHK_IMPLY(a_fail_clean, rsp_valid && rsp_status, !side_fx, "failed beat carries side effects")
   `CHK_IMPLY(a_wpid_zero, rsp_valid && !rsp_write_back, rsp_write_page_id == '0, "id without write-back")
   `CHK_IMPLY(a_fill_last, rsp_valid && rsp_fill_kind != pbp_pkg::FILL_NONE, rsp_last && !rsp_release_page, "bad refill beat")
   `CHK_ALWAYS(a_fill_code, !rsp_valid || fill_known, "undefined fill kind")

endmodule

bind page_buffer_pool_lru pbp_checker u_pbp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_frame         (rsp_frame),
   .rsp_write_back    (rsp_write_back),
   .rsp_write_page_id (rsp_write_page_id),
   .rsp_fill_kind     (rsp_fill_kind),
   .rsp_release_page  (rsp_release_page),
   .rsp_last          (rsp_last)
);

`default_nettype wire
